FILE: design/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

  // Fixed field widths of the query and result beats.
  localparam int LIMIT_W   = 17;
  localparam int COUNT_W   = 13;
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_BASE_RD,
    ST_BASE_CHK,
    ST_MARK,
    ST_COUNT,
    ST_DONE
  } spc_state_t;

  // Command to the bitmap memory. Reads and writes never share a cycle.
  typedef struct packed {
    logic wr_en;
    logic wr_bit;
    logic rd_en;
  } mem_cmd_t;

endpackage

FILE: design/spc_bitmap.sv
`timescale 1ns / 1ps

module spc_bitmap #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  spc_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]     addr,
  output logic              rd_data
);
  import spc_pkg::*;

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= cmd.wr_bit;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/spc_ctrl.sv
`timescale 1ns / 1ps

module spc_ctrl #(
  parameter int MAX_LIMIT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spc_pkg::LIMIT_W-1:0] in_limit,
  output spc_pkg::mem_cmd_t           mem_cmd,
  output logic [$clog2(MAX_LIMIT)-1:0] mem_addr,
  input  logic                        mem_rd_data,
  input  logic                        out_busy,
  output logic                        res_valid,
  output logic [spc_pkg::COUNT_W-1:0] res_count
);
  import spc_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT);
  localparam int LW = $clog2(MAX_LIMIT + 1);
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int HW = LW / 2 + 2;

  spc_state_t state_r, state_nxt;
  logic             rd_pend_r;
  logic [LW-1:0]    lim_r;
  logic [LW-1:0]    idx_r;
  logic [LW:0]      mult_r;
  logic [LW:0]      sq_r;
  logic [HW-1:0]    base_r;
  logic [COUNT_W-1:0] count_r;

  logic [CW-1:0] lim_ext;
  logic [LW-1:0] lim_sat;
  logic [LW:0]   base_ext;
  logic          idx_lt;
  logic          mult_lt;
  logic          sq_le;

  assign lim_ext  = CW'(in_limit);
  assign lim_sat  = (lim_ext > CW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(lim_ext);
  assign base_ext = {{(LW + 1 - HW){1'b0}}, base_r};
  assign idx_lt   = idx_r < lim_r;
  assign mult_lt  = mult_r < {1'b0, lim_r};
  assign sq_le    = sq_r <= {1'b0, lim_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_FILL;
      ST_FILL:     if (!idx_lt) state_nxt = ST_BASE_RD;
      ST_BASE_RD:  state_nxt = sq_le ? ST_BASE_CHK : ST_COUNT;
      ST_BASE_CHK: state_nxt = mem_rd_data ? ST_MARK : ST_BASE_RD;
      ST_MARK:     if (!mult_lt) state_nxt = ST_BASE_RD;
      ST_COUNT:    if (!idx_lt && !rd_pend_r) state_nxt = ST_DONE;
      ST_DONE:     if (!out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_cmd   = '0;
    mem_addr  = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FILL: begin
        mem_cmd.wr_en  = idx_lt;
        mem_cmd.wr_bit = 1'b1;
      end
      ST_BASE_RD: begin
        mem_cmd.rd_en = sq_le;
        mem_addr      = base_ext[AW-1:0];
      end
      ST_MARK: begin
        mem_cmd.wr_en = mult_lt;
        mem_addr      = mult_r[AW-1:0];
      end
      ST_COUNT: begin
        mem_cmd.rd_en = idx_lt;
      end
      ST_DONE: begin
        res_valid = !out_busy;
      end
      default: ;
    endcase
  end

  assign res_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_COUNT) && idx_lt;
    end
  end

  // Marking starts at base squared and skips bases already cleared: every
  // entry those passes would clear is cleared by a smaller prime anyway.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lim_r <= lim_sat;
          idx_r <= '0;
        end
      end
      ST_FILL: begin
        if (idx_lt) begin
          idx_r <= idx_r + 1'b1;
        end else begin
          base_r <= HW'(2);
          sq_r   <= (LW + 1)'(4);
        end
      end
      ST_BASE_RD: begin
        if (!sq_le) begin
          idx_r   <= LW'(2);
          count_r <= '0;
        end
      end
      ST_BASE_CHK: begin
        if (mem_rd_data) begin
          mult_r <= sq_r;
        end else begin
          base_r <= base_r + 1'b1;
          sq_r   <= sq_r + {base_ext[LW-1:0], 1'b0} + 1'b1;
        end
      end
      ST_MARK: begin
        if (mult_lt) begin
          mult_r <= mult_r + base_ext;
        end else begin
          base_r <= base_r + 1'b1;
          sq_r   <= sq_r + {base_ext[LW-1:0], 1'b0} + 1'b1;
        end
      end
      ST_COUNT: begin
        if (idx_lt) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_pend_r && mem_rd_data && (count_r != COUNT_SAT)) begin
          count_r <= count_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/sieve_prime_counter_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                  Beat
// query     in_valid, in_ready, in_limit           one limit (17 bits)
// result    out_valid, out_ready, out_prime_count  one prime count (13 bits)
//
// One query at a time. With L the limit after saturation to MAX_LIMIT, a query
// first sets the bitmap entries below L, then reads the bit of every base b with
// b*b <= L and, for every prime base p, clears the multiples of p from p*p below
// L, and last counts the entries from 2 still set. The single-port bitmap serializes these passes.
// Reset clears only the control state; the bitmap needs no clearing pass.
// A held result stalls the block until out_ready takes it.
module sieve_prime_counter_core #(
  parameter int MAX_LIMIT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spc_pkg::LIMIT_W-1:0] in_limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spc_pkg::COUNT_W-1:0] out_prime_count
);
  import spc_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT);

  mem_cmd_t           mem_cmd;
  logic [AW-1:0]      mem_addr;
  logic               mem_rd_data;
  logic               out_busy;
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  spc_ctrl #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_limit    (in_limit),
    .mem_cmd     (mem_cmd),
    .mem_addr    (mem_addr),
    .mem_rd_data (mem_rd_data),
    .out_busy    (out_busy),
    .res_valid   (res_valid),
    .res_count   (res_count)
  );

  spc_bitmap #(
    .DEPTH (MAX_LIMIT),
    .AW    (AW)
  ) u_bitmap (
    .clk     (clk),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .rd_data (mem_rd_data)
  );

  assign out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_count_r <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_count_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_busy)
    else $error("result loaded while the output beat is still held");

  a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("query port stayed open after a beat was taken");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(mem_cmd.wr_en || mem_cmd.rd_en))
    else $error("bitmap accessed while the block is idle");
`endif

endmodule
